@@ rtl/core/dtc_pkg.sv @@
// ============================================================================
// dtc_pkg
// Shared constants for the depth to colour and millimetres pipeline.
// ============================================================================
package dtc_pkg;

   localparam int GAMMA_ENTRIES_DEF = 2048;
   localparam int DEPTH_BITS_DEF    = 24;

   localparam int REQ_W    = 24;
   localparam int RSP_W    = 40;
   localparam int PLANE_W  = 16;
   localparam int SCALE_W  = 22;
   localparam int OFFSET_W = 12;
   localparam int Z_W      = 16;
   localparam int COLOR_W  = 8;
   localparam int ROM_W    = 14;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAR    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET = 8'd3;

   localparam logic [PLANE_W-1:0]  NEAR_RST   = 16'd700;
   localparam logic [PLANE_W-1:0]  FAR_RST    = 16'd20000;
   localparam logic [SCALE_W-1:0]  SCALE_RST  = 22'd348000;
   localparam logic [OFFSET_W-1:0] OFFSET_RST = 12'd1090;

endpackage

@@ rtl/core/dtc_pipe_div.sv @@
// ============================================================================
// dtc_pipe_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ============================================================================
module dtc_pipe_div #(
   parameter int W   = 28,
   parameter int DVW = 16,
   parameter int QB  = 12,
   parameter int SW  = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [W-1:0]   dividend,
   input  logic [DVW-1:0] divisor,
   input  logic [SW-1:0]  side_in,
   output logic           out_valid,
   output logic [QB-1:0]  quotient,
   output logic [SW-1:0]  side_out
);

   logic [W-1:0]   rem_ff  [QB-1];
   logic [DVW-1:0] dvs_ff  [QB-1];
   logic [QB-1:0]  quo_ff  [QB];
   logic [SW-1:0]  side_ff [QB];
   logic           vld_ff  [QB];

   for (genvar s = 0; s < QB; s++) begin : g_stage
      localparam int SH = QB - 1 - s;
      logic [W-1:0]   rem_prev;
      logic [DVW-1:0] dvs_prev;
      logic [QB-1:0]  quo_prev;
      logic [SW-1:0]  side_prev;
      logic           vld_prev;
      logic [W-1:0]   trial;
      logic           ge;
      logic [QB-1:0]  quo_in;

      if (s == 0) begin : g_first
         assign rem_prev  = dividend;
         assign dvs_prev  = divisor;
         assign quo_prev  = '0;
         assign side_prev = side_in;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign dvs_prev  = dvs_ff[s-1];
         assign quo_prev  = quo_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign vld_prev  = vld_ff[s-1];
      end

      assign trial = W'(dvs_prev) << SH;
      assign ge    = rem_prev >= trial;

      always_comb begin
         quo_in     = quo_prev;
         quo_in[SH] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[s]  <= quo_in;
            side_ff[s] <= side_prev;
         end
      end

      if (s < QB - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= ge ? rem_prev - trial : rem_prev;
               dvs_ff[s] <= dvs_prev;
            end
         end
      end
   end

   assign out_valid = vld_ff[QB-1];
   assign quotient  = quo_ff[QB-1];
   assign side_out  = side_ff[QB-1];

endmodule

@@ rtl/core/dtc_gamma_rom.sv @@
// ============================================================================
// dtc_gamma_rom
// Cubic gamma memory, filled after reset by an add/subtract sequencer.
// ============================================================================
module dtc_gamma_rom #(
   parameter int ENTRIES = 2048,
   parameter int AW      = 11
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [dtc_pkg::ROM_W-1:0] rd_data,
   output logic                      fill_done
);

   import dtc_pkg::*;

   localparam longint unsigned CUBE = 64'(ENTRIES) * 64'(ENTRIES) * 64'(ENTRIES);
   localparam int RW = $clog2(CUBE) + 8;
   localparam int TW = $clog2(3 * ENTRIES * ENTRIES) + 1;
   localparam int UW = $clog2(6 * ENTRIES) + 1;
   localparam logic [RW-1:0] CUBE_R = RW'(CUBE);
   localparam logic [AW-1:0] LAST   = AW'(ENTRIES - 1);

   typedef enum logic {
      ST_FILL,
      ST_DONE
   } state_type;

   state_type        state_ff;
   logic [AW-1:0]    k_ff;
   logic [RW-1:0]    r_ff;
   logic [ROM_W-1:0] q_ff;
   logic [TW-1:0]    t_ff;
   logic [UW-1:0]    u_ff;
   logic             sub;
   logic             wr_en;
   logic [RW-1:0]    step;
   logic [ROM_W-1:0] mem [ENTRIES];
   logic [ROM_W-1:0] rd_data_ff;

   // r holds k^3*9216 - q*G^3; t is 3k^2+3k+1, u is 6k+6
   assign sub   = r_ff >= CUBE_R;
   assign wr_en = (state_ff == ST_FILL) && !sub;
   assign step  = (RW'(t_ff) << 13) + (RW'(t_ff) << 10);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         k_ff     <= '0;
         r_ff     <= '0;
         q_ff     <= '0;
         t_ff     <= TW'(1);
         u_ff     <= UW'(6);
      end else begin
         unique case (state_ff)
            ST_FILL: begin
               if (sub) begin
                  r_ff <= r_ff - CUBE_R;
                  q_ff <= q_ff + ROM_W'(1);
               end else if (k_ff == LAST) begin
                  state_ff <= ST_DONE;
               end else begin
                  k_ff <= k_ff + AW'(1);
                  r_ff <= r_ff + step;
                  t_ff <= t_ff + TW'(u_ff);
                  u_ff <= u_ff + UW'(6);
               end
            end
            ST_DONE: begin
               state_ff <= ST_DONE;
            end
            default: begin
               state_ff <= ST_FILL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[k_ff] <= q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data   = rd_data_ff;
   assign fill_done = (state_ff == ST_DONE);

endmodule

@@ rtl/core/depth_to_colour_and_millimetres.sv @@
// ============================================================================
// depth_to_colour_and_millimetres
// Depth buffer sample to linear millimetres and a six-ramp false colour.
// ============================================================================
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  req_tdata: depth_code
//  rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: red, green, blue, depth_mm
//  csr      in   csr_valid/csr_ready    csr_index, csr_data
//
//  One item per clock while the result is not stalled; the pipeline holds
//  the 16-step depth division and the 12-step disparity division.
//  After reset the gamma memory is filled by its sequencer; req_tready
//  stays low until the fill is done.
//  A stalled result holds the whole pipeline; csr writes are always taken.
// ============================================================================
module depth_to_colour_and_millimetres #(
   parameter int GAMMA_ENTRIES = dtc_pkg::GAMMA_ENTRIES_DEF,
   parameter int DEPTH_BITS    = dtc_pkg::DEPTH_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dtc_pkg::REQ_W-1:0]       req_tdata,   // [23:0] depth_code
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dtc_pkg::RSP_W-1:0]       rsp_tdata,   // red, green, blue, depth_mm
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dtc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dtc_pkg::CSR_DATA_W-1:0]  csr_data
);

   import dtc_pkg::*;

   localparam int DB   = DEPTH_BITS;
   localparam int AW   = $clog2(GAMMA_ENTRIES);
   localparam int PW   = DB + 17;
   localparam int NW   = DB + 32;
   localparam int DW   = DB + 18;
   localparam int DVW1 = DB + 17;
   localparam int CW   = DB + 33;
   localparam int EW   = Z_W + OFFSET_W;
   localparam int KW   = OFFSET_W + 1;
   localparam logic [KW-1:0] KD_TOP = KW'(GAMMA_ENTRIES - 1);

   localparam logic [5:0] RAMP_WHITE_BLUE = 6'd0;
   localparam logic [5:0] RAMP_BLUE_CYAN  = 6'd1;
   localparam logic [5:0] RAMP_CYAN_GREEN = 6'd2;
   localparam logic [5:0] RAMP_GREEN_YEL  = 6'd3;
   localparam logic [5:0] RAMP_YEL_RED    = 6'd4;
   localparam logic [5:0] RAMP_RED_BLACK  = 6'd5;

   // configuration
   logic [PLANE_W-1:0]  near_ff;
   logic [PLANE_W-1:0]  far_ff;
   logic [SCALE_W-1:0]  scale_ff;
   logic [OFFSET_W-1:0] offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff   <= NEAR_RST;
         far_ff    <= FAR_RST;
         scale_ff  <= SCALE_RST;
         offset_ff <= OFFSET_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NEAR:   near_ff   <= csr_data[PLANE_W-1:0];
            CSR_FAR:    far_ff    <= csr_data[PLANE_W-1:0];
            CSR_SCALE:  scale_ff  <= csr_data[SCALE_W-1:0];
            CSR_OFFSET: offset_ff <= csr_data[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // flow control
   logic adv;
   logic accept;
   logic fill_done;
   logic rsp_tvalid_ff;
   logic [RSP_W-1:0] rsp_tdata_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv && fill_done;
   assign accept     = req_tvalid && req_tready;

   // stage A: products
   logic [DB-1:0]          code;
   logic signed [16:0]     fmn;
   logic [31:0]            nf_in;
   logic signed [PW-1:0]   cd_in;
   logic                   a_vld_ff;
   logic [31:0]            a_nf_ff;
   logic signed [PW-1:0]   a_cd_ff;

   assign code  = DB'(req_tdata);
   assign fmn   = $signed({1'b0, far_ff}) - $signed({1'b0, near_ff});
   assign nf_in = 32'(near_ff) * 32'(far_ff);
   assign cd_in = PW'($signed({1'b0, code})) * PW'(fmn);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_nf_ff <= nf_in;
         a_cd_ff <= cd_in;
      end
   end

   // stage B: numerator and denominator
   logic                 b_vld_ff;
   logic [NW-1:0]        b_num_ff;
   logic signed [DW-1:0] b_den_ff;
   logic signed [DW-1:0] far_sh;

   assign far_sh = $signed(DW'({far_ff, {DB{1'b0}}}));

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_num_ff <= {a_nf_ff, {DB{1'b0}}};
         b_den_ff <= far_sh - {a_cd_ff[PW-1], a_cd_ff};
      end
   end

   // stage C: saturation check ahead of the division
   logic            den_pos;
   logic [DVW1-1:0] dpos;
   logic            sat_in;
   logic            c_vld_ff;
   logic [CW-1:0]   c_dvd_ff;
   logic [DVW1-1:0] c_dvs_ff;
   logic            c_sat_ff;

   assign den_pos = !b_den_ff[DW-1] && (b_den_ff != '0);
   assign dpos    = b_den_ff[DVW1-1:0];
   assign sat_in  = !den_pos || (CW'(b_num_ff) >= {dpos, 16'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_dvd_ff <= CW'(b_num_ff);
         c_dvs_ff <= dpos;
         c_sat_ff <= sat_in;
      end
   end

   logic           zd_vld;
   logic [Z_W-1:0] zd_quo;
   logic           zd_sat;

   dtc_pipe_div #(
      .W   (CW),
      .DVW (DVW1),
      .QB  (Z_W),
      .SW  (1)
   ) u_depth_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (c_vld_ff),
      .dividend  (c_dvd_ff),
      .divisor   (c_dvs_ff),
      .side_in   (c_sat_ff),
      .out_valid (zd_vld),
      .quotient  (zd_quo),
      .side_out  (zd_sat)
   );

   // stage E: disparity numerator, ceil(scale / z)
   logic [Z_W-1:0] z_e;
   logic [EW-1:0]  num2;
   logic           force_in;
   logic           e_vld_ff;
   logic [EW-1:0]  e_num_ff;
   logic [Z_W-1:0] e_z_ff;
   logic           e_force_ff;

   assign z_e      = zd_sat ? {Z_W{1'b1}} : zd_quo;
   assign num2     = EW'(scale_ff) + EW'(z_e) - EW'(1);
   assign force_in = (z_e == '0) || (num2 >= {z_e, {OFFSET_W{1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= zd_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_num_ff   <= num2;
         e_z_ff     <= z_e;
         e_force_ff <= force_in;
      end
   end

   logic                dd_vld;
   logic [OFFSET_W-1:0] dd_quo;
   logic [Z_W:0]        dd_side;

   dtc_pipe_div #(
      .W   (EW),
      .DVW (Z_W),
      .QB  (OFFSET_W),
      .SW  (Z_W + 1)
   ) u_disp_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (e_vld_ff),
      .dividend  (e_num_ff),
      .divisor   (e_z_ff),
      .side_in   ({e_force_ff, e_z_ff}),
      .out_valid (dd_vld),
      .quotient  (dd_quo),
      .side_out  (dd_side)
   );

   // stage F: disparity, clamped to the gamma range
   logic [OFFSET_W-1:0] diff;
   logic [OFFSET_W-1:0] kd_in;
   logic                f_vld_ff;
   logic [AW-1:0]       f_kd_ff;
   logic [Z_W-1:0]      f_z_ff;

   always_comb begin
      if (dd_side[Z_W] || (dd_quo >= offset_ff)) begin
         diff = '0;
      end else begin
         diff = offset_ff - dd_quo;
      end
      if (KW'(diff) > KD_TOP) begin
         kd_in = KD_TOP[OFFSET_W-1:0];
      end else begin
         kd_in = diff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= dd_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_kd_ff <= kd_in[AW-1:0];
         f_z_ff  <= dd_side[Z_W-1:0];
      end
   end

   // stage G: gamma lookup
   logic [ROM_W-1:0] pval;
   logic             g_vld_ff;
   logic [Z_W-1:0]   g_z_ff;

   dtc_gamma_rom #(
      .ENTRIES (GAMMA_ENTRIES),
      .AW      (AW)
   ) u_gamma (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (adv),
      .rd_addr   (f_kd_ff),
      .rd_data   (pval),
      .fill_done (fill_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_z_ff <= f_z_ff;
      end
   end

   // stage H: palette and result register
   logic [COLOR_W-1:0] lb;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;

   assign lb = pval[COLOR_W-1:0];

   always_comb begin
      red   = '0;
      green = '0;
      blue  = '0;
      case (pval[ROM_W-1:COLOR_W])
         RAMP_WHITE_BLUE: begin red = ~lb; green = ~lb; blue = '1; end
         RAMP_BLUE_CYAN:  begin green = lb; blue = '1; end
         RAMP_CYAN_GREEN: begin green = '1; blue = ~lb; end
         RAMP_GREEN_YEL:  begin red = lb; green = '1; end
         RAMP_YEL_RED:    begin red = '1; green = ~lb; end
         RAMP_RED_BLACK:  begin red = ~lb; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= g_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= {g_z_ff, blue, green, red};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef NO_ASSERTIONS
   // zero depth forces disparity 0, the white end of the palette
   a_zero_depth_white: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[39:24] == 16'd0)) |-> (rsp_tdata[23:0] == 24'hFFFFFF))
      else $error("zero depth item not white");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("item taken while result stalled");

   a_no_result_in_fill: assert property (@(posedge clock) disable iff (reset)
      !fill_done |-> !rsp_tvalid)
      else $error("result before gamma fill done");
`endif

endmodule

@@ sim/depth_to_colour_and_millimetres_check.sv @@
// ============================================================================
// depth_to_colour_and_millimetres_check
// Watches the req, rsp and csr channels and scores every result item.
// Keeps its own copy of the plane, scale and offset registers, predicts the
// colour and millimetre value of each accepted depth item, and compares the
// results in order, field by field.
// ============================================================================
module depth_to_colour_and_millimetres_check
   import dtc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_W-1:0]       req_tdata,    // [23:0] depth_code
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_W-1:0]       rsp_tdata,    // [7:0] red, [15:8] green,
                                                // [23:16] blue, [39:24] depth_mm
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     error_count,
   output int                     backlog
);

   typedef longint unsigned u64_t;

   typedef struct packed {
      logic [Z_W-1:0]     depth_mm;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
   } pixel_t;

   typedef enum int {
      RAMP_WHITE_TO_BLUE,
      RAMP_BLUE_TO_CYAN,
      RAMP_CYAN_TO_GREEN,
      RAMP_GREEN_TO_YELLOW,
      RAMP_YELLOW_TO_RED,
      RAMP_RED_TO_BLACK
   } ramp_t;

   logic [PLANE_W-1:0]  near_mm;
   logic [PLANE_W-1:0]  far_mm;
   logic [SCALE_W-1:0]  scale;
   logic [OFFSET_W-1:0] offset;

   pixel_t pixel_q[$];
   pixel_t want;
   pixel_t seen;
   int     result_count;

   function automatic logic [Z_W-1:0] linear_depth(input logic [REQ_W-1:0] code);
      u64_t   num;
      u64_t   z;
      longint den;
      num = (u64_t'(near_mm) * u64_t'(far_mm)) << DEPTH_BITS_DEF;
      den = (longint'(far_mm) <<< DEPTH_BITS_DEF)
          - longint'(code) * (longint'(far_mm) - longint'(near_mm));
      if (den <= 0)
         return '1;
      z = num / u64_t'(den);
      if (z > u64_t'(16'hFFFF))
         return '1;
      return z[Z_W-1:0];
   endfunction

   function automatic u64_t gamma_index(input logic [Z_W-1:0] z);
      u64_t q;
      if (z == '0)
         return 0;
      q = (u64_t'(scale) + u64_t'(z) - 1) / u64_t'(z);
      if (q >= u64_t'(offset))
         return 0;
      q = u64_t'(offset) - q;
      return (q > GAMMA_ENTRIES_DEF - 1) ? u64_t'(GAMMA_ENTRIES_DEF - 1) : q;
   endfunction

   // cubic gamma: floor(k^3 * 36 * 256 / entries^3)
   function automatic logic [ROM_W-1:0] gamma_word(input u64_t k);
      u64_t g;
      g = u64_t'(GAMMA_ENTRIES_DEF);
      return ROM_W'((k * k * k * 64'd9216) / (g * g * g));
   endfunction

   function automatic pixel_t predict_pixel(input logic [REQ_W-1:0] code);
      pixel_t             p;
      logic [ROM_W-1:0]   w;
      logic [COLOR_W-1:0] lb;
      p.depth_mm = linear_depth(code);
      w = gamma_word(gamma_index(p.depth_mm));
      lb = w[COLOR_W-1:0];
      p.red = '0;
      p.green = '0;
      p.blue = '0;
      case (w[ROM_W-1:8])
         RAMP_WHITE_TO_BLUE: begin
            p.red = 8'hFF - lb;
            p.green = 8'hFF - lb;
            p.blue = 8'hFF;
         end
         RAMP_BLUE_TO_CYAN: begin
            p.green = lb;
            p.blue = 8'hFF;
         end
         RAMP_CYAN_TO_GREEN: begin
            p.green = 8'hFF;
            p.blue = 8'hFF - lb;
         end
         RAMP_GREEN_TO_YELLOW: begin
            p.red = lb;
            p.green = 8'hFF;
         end
         RAMP_YELLOW_TO_RED: begin
            p.red = 8'hFF;
            p.green = 8'hFF - lb;
         end
         RAMP_RED_TO_BLACK: begin
            p.red = 8'hFF - lb;
         end
         default: ;
      endcase
      return p;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         near_mm = NEAR_RST;
         far_mm = FAR_RST;
         scale = SCALE_RST;
         offset = OFFSET_RST;
         pixel_q.delete();
         error_count = 0;
         result_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NEAR:   near_mm = csr_data[PLANE_W-1:0];
               CSR_FAR:    far_mm = csr_data[PLANE_W-1:0];
               CSR_SCALE:  scale = csr_data[SCALE_W-1:0];
               CSR_OFFSET: offset = csr_data[OFFSET_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (pixel_q.size() == 0) begin
               if (error_count < 10)
                  $display("result %0d: unexpected item rgb %0d,%0d,%0d mm %0d",
                           result_count, seen.red, seen.green, seen.blue,
                           seen.depth_mm);
               error_count++;
            end else begin
               want = pixel_q.pop_front();
               if (want.red != seen.red || want.green != seen.green ||
                   want.blue != seen.blue || want.depth_mm != seen.depth_mm) begin
                  if (error_count < 10)
                     $display("result %0d: rgb %0d,%0d,%0d mm %0d, want rgb %0d,%0d,%0d mm %0d",
                              result_count, seen.red, seen.green, seen.blue,
                              seen.depth_mm, want.red, want.green, want.blue,
                              want.depth_mm);
                  error_count++;
               end
            end
            result_count++;
         end
         if (req_tvalid && req_tready)
            pixel_q.insert(pixel_q.size(), predict_pixel(req_tdata));
      end
      backlog = pixel_q.size();
   end

endmodule

@@ sim/depth_to_colour_and_millimetres_test.sv @@
// ============================================================================
// depth_to_colour_and_millimetres_test
// Stimulus and verdict for the depth to colour and millimetres pipeline.
// Streams depth items through a series of plane, scale and offset settings,
// extremes and reversed or degenerate planes among them, with bursty input,
// a stalling output and one long output hold; a checker scores each result.
// ============================================================================
module depth_to_colour_and_millimetres_test;
   import dtc_pkg::*;

   localparam int WATCHDOG_LIMIT = 60000;
   localparam int LONG_HOLD      = 400;
   localparam int DRAIN_CYCLES   = 60;

   typedef enum int {FLOW_OPEN, FLOW_BUSY, FLOW_SPARSE, FLOW_PERIODIC} flow_t;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int   error_count;
   int   backlog;
   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;
   int   quiet_cycles = 0;
   int   items_sent;
   int   settings_done;
   int   burst_left;
   bit   gapless;
   bit   long_hold_req;
   bit   long_hold_done = 1'b0;

   depth_to_colour_and_millimetres dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   depth_to_colour_and_millimetres_check pixel_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .error_count (error_count),
      .backlog     (backlog)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      csr_taken <= csr_valid && csr_ready;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $display("[depth_to_colour_and_millimetres] ERROR");
      $finish;
   end

   // output side: random stretches of flow, plus one long hold on request
   initial begin
      flow_t flow;
      int    stretch_left;
      int    tick;
      flow = FLOW_OPEN;
      stretch_left = 0;
      tick = 0;
      rsp_tready = 1'b0;
      while (reset)
         @(negedge clock);
      forever begin
         if (long_hold_req && !long_hold_done) begin
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_done = 1'b1;
         end
         if (stretch_left == 0) begin
            flow = flow_t'($urandom_range(0, 3));
            stretch_left = $urandom_range(5, 80);
         end
         stretch_left--;
         tick++;
         case (flow)
            FLOW_OPEN:     rsp_tready = 1'b1;
            FLOW_BUSY:     rsp_tready = ($urandom_range(0, 3) != 0);
            FLOW_SPARSE:   rsp_tready = ($urandom_range(0, 3) == 0);
            FLOW_PERIODIC: rsp_tready = (tick % 4 != 3);
            default:       rsp_tready = 1'b1;
         endcase
         @(negedge clock);
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data = data;
      do @(negedge clock); while (!csr_taken);
   endtask

   // upper data bits carry noise; an unused index is written too
   task automatic apply_settings(input logic [PLANE_W-1:0] near_v,
                                 input logic [PLANE_W-1:0] far_v,
                                 input logic [SCALE_W-1:0] scale_v,
                                 input logic [OFFSET_W-1:0] offset_v);
      logic [CSR_DATA_W-1:0] data;
      csr_write(CSR_OFFSET + CSR_INDEX_W'($urandom_range(1, 252)), $urandom());
      data = $urandom();
      data[PLANE_W-1:0] = near_v;
      csr_write(CSR_NEAR, data);
      data = $urandom();
      data[PLANE_W-1:0] = far_v;
      csr_write(CSR_FAR, data);
      data = $urandom();
      data[SCALE_W-1:0] = scale_v;
      csr_write(CSR_SCALE, data);
      data = $urandom();
      data[OFFSET_W-1:0] = offset_v;
      csr_write(CSR_OFFSET, data);
      csr_valid = 1'b0;
      settings_done++;
   endtask

   task automatic push_depth(input logic [REQ_W-1:0] code);
      if (!gapless) begin
         if (burst_left == 0) begin
            req_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;
      end
      req_tvalid = 1'b1;
      req_tdata = code;
      do @(negedge clock); while (!req_taken);
      items_sent++;
   endtask

   task automatic drain_pixels();
      req_tvalid = 1'b0;
      while (backlog != 0)
         @(negedge clock);
   endtask

   // mostly uniform, some near either end of the depth range
   function automatic logic [REQ_W-1:0] random_depth_code();
      int unsigned      pick;
      logic [REQ_W-1:0] code;
      pick = $urandom_range(0, 99);
      code = REQ_W'($urandom());
      if (pick < 15)
         code = code >> $urandom_range(8, 23);
      else if (pick < 30)
         code = ~(code >> $urandom_range(4, 23));
      return code;
   endfunction

   task automatic run_depths(input int count);
      push_depth('0);
      push_depth('1);
      repeat (count) push_depth(random_depth_code());
      drain_pixels();
   endtask

   initial begin
      logic [REQ_W-1:0] directed [16];
      directed = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'hFFFFFE,
                   24'h800000, 24'h400000, 24'hC00000, 24'hE00000,
                   24'hF00000, 24'hF80000, 24'hFC0000, 24'hAAAAAA,
                   24'h555555, 24'h0000FF, 24'hFF0000, 24'h7FFFFF};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      gapless = 1'b0;
      long_hold_req = 1'b0;
      burst_left = 0;
      items_sent = 0;
      settings_done = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         push_depth(directed[i]);
      drain_pixels();

      // input kept busy while the output holds off
      gapless = 1'b1;
      long_hold_req = 1'b1;
      apply_settings(NEAR_RST, FAR_RST, SCALE_RST, OFFSET_RST);
      run_depths(160);
      gapless = 1'b0;

      apply_settings(16'd1, 16'd65535, 22'd348000, 12'd1090);
      run_depths(60);
      apply_settings(16'd1, 16'd2, 22'h3FFFFF, 12'hFFF);
      run_depths(50);
      apply_settings(16'hFFFF, 16'hFFFF, 22'd0, 12'hFFF);
      run_depths(40);
      apply_settings(16'd30000, 16'd500, 22'd348000, 12'd1090);   // reversed planes
      run_depths(50);
      apply_settings(16'd0, 16'd20000, 22'd1000, 12'd2000);       // depth of zero mm
      run_depths(40);
      apply_settings(16'd1000, 16'd0, 22'd348000, 12'd1090);      // zero denominator
      run_depths(40);
      apply_settings(16'd300, 16'd8000, 22'd0, 12'd0);
      run_depths(40);
      apply_settings(16'd500, 16'd4000, 22'd200000, 12'd2047);
      run_depths(60);
      apply_settings(16'd1, 16'd65535, 22'h3FFFFF, 12'd0);
      run_depths(40);
      repeat (4) begin
         apply_settings(PLANE_W'($urandom_range(1, 65535)),
                        PLANE_W'($urandom_range(2, 65535)),
                        SCALE_W'($urandom_range(0, 4194303)),
                        OFFSET_W'($urandom_range(0, 4095)));
         run_depths(60);
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d depth items over %0d register settings (%0d written)",
               items_sent, settings_done + 1, settings_done);
      $display("one output hold of %0d cycles with the input kept busy", LONG_HOLD);
      if (error_count == 0 && backlog == 0)
         $display("[depth_to_colour_and_millimetres] OK");
      else
         $display("[depth_to_colour_and_millimetres] ERROR");
      $finish;
   end

endmodule
